// ===== rtl/he_pkg.sv =====
// he_pkg: shared widths, limits and command codes for the histogram equalizer.
// No dependencies; used by histogram_equalizer, he_divider and he_checker.
package he_pkg;

   localparam int BIN_COUNT = 256;
   localparam int BIN_AW    = $clog2(BIN_COUNT);
   localparam int PIX_W     = 8;
   localparam int CMD_W     = 2;
   localparam int COUNT_W   = 21;
   localparam int PROD_W    = COUNT_W + 8;   // count times full scale
   localparam int QUO_W     = 8;
   localparam int STEP_W    = $clog2(QUO_W);
   localparam int IDX_W     = BIN_AW + 1;

   localparam logic [COUNT_W-1:0] MAX_PIXELS = COUNT_W'(1048576);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_COUNT = 2'd1,
      CMD_MAP   = 2'd2
   } cmd_type;

endpackage

// ===== rtl/histogram_equalizer.sv =====
// histogram_equalizer: 256-bin histogram, prefix-sum build and equalizing map.
// Depends on he_pkg and he_divider.
//
//   channel   ports                                        handshake
//   request   req_command, req_pixel_value                 start && !busy
//   response  rsp_equalized_value, rsp_degenerate          rsp_strobe, one cycle
//
// Clear completes on accept and busy stays low; count reads, then writes back
// the bin memory. Map, when the prefix sums are current, runs lookup, setup,
// then the bit-serial divider; a degenerate map ends at setup with no divide.
// The first map after a clear or count first sweeps the bin memory into the
// prefix-sum memory, then passes through a lookup state. Reset is synchronous
// and clears the bin valid bits. The receiver cannot stall.
module histogram_equalizer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [he_pkg::CMD_W-1:0]     req_command,
   input  logic [he_pkg::PIX_W-1:0]     req_pixel_value,
   output logic                         rsp_strobe,
   output logic [he_pkg::QUO_W-1:0]     rsp_equalized_value,
   output logic                         rsp_degenerate
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COUNT,
      S_BUILD,
      S_LOOKUP,
      S_SETUP,
      S_DIVIDE
   } state_type;

   state_type                        state_ff;
   logic [he_pkg::BIN_AW-1:0]        pix_ff;
   logic [he_pkg::COUNT_W-1:0]       total_ff;
   logic [he_pkg::COUNT_W-1:0]       lowest_ff;
   logic                             ready_ff;
   logic [he_pkg::IDX_W-1:0]         idx_ff;
   logic [he_pkg::COUNT_W-1:0]       run_ff;
   logic                             strobe_ff;
   logic [he_pkg::QUO_W-1:0]         eq_ff;
   logic                             deg_ff;

   logic [he_pkg::COUNT_W-1:0]       bin_mem [he_pkg::BIN_COUNT];
   logic [he_pkg::BIN_COUNT-1:0]     bin_valid_ff;
   logic [he_pkg::COUNT_W-1:0]       bin_rd_ff;
   logic                             bin_rd_vld_ff;
   logic [he_pkg::COUNT_W-1:0]       cum_mem [he_pkg::BIN_COUNT];
   logic [he_pkg::COUNT_W-1:0]       cum_rd_ff;

   logic                             accept;
   he_pkg::cmd_type                  cmd;
   logic                             bin_re;
   logic [he_pkg::BIN_AW-1:0]        bin_raddr;
   logic                             bin_we;
   logic [he_pkg::COUNT_W-1:0]       bin_eff;
   logic                             cum_re;
   logic [he_pkg::BIN_AW-1:0]        cum_raddr;
   logic                             cum_we;
   logic [he_pkg::BIN_AW-1:0]        cum_waddr;
   logic [he_pkg::COUNT_W-1:0]       cum_wdata;
   logic                             room;

   logic [he_pkg::COUNT_W-1:0]       span;
   logic                             degen;
   logic [he_pkg::COUNT_W-1:0]       num;
   logic [he_pkg::PROD_W-1:0]        dividend;
   logic                             div_load;
   logic                             div_done;
   logic [he_pkg::QUO_W-1:0]         quotient;

   assign accept  = start && !busy;
   assign cmd     = he_pkg::cmd_type'(req_command);
   assign room    = (total_ff < he_pkg::MAX_PIXELS);
   assign bin_eff = bin_rd_vld_ff ? bin_rd_ff : '0;

   // bin memory: read on count accept or during the build sweep
   assign bin_re    = (accept && cmd == he_pkg::CMD_COUNT) ||
                      (state_ff == S_BUILD && !idx_ff[he_pkg::BIN_AW]);
   assign bin_raddr = (state_ff == S_BUILD) ? idx_ff[he_pkg::BIN_AW-1:0] : req_pixel_value;
   assign bin_we    = (state_ff == S_COUNT) && room;

   // prefix-sum memory: in the sweep, written from the registered bin read of the previous index
   assign cum_we    = (state_ff == S_BUILD) && (idx_ff != '0);
   assign cum_waddr = he_pkg::BIN_AW'(idx_ff - 1'b1);
   assign cum_wdata = run_ff + bin_eff;
   assign cum_re    = (accept && cmd == he_pkg::CMD_MAP && ready_ff) ||
                      (state_ff == S_LOOKUP);
   assign cum_raddr = (state_ff == S_LOOKUP) ? pix_ff : req_pixel_value;

   always_ff @(posedge clock) begin
      if (bin_we) begin
         bin_mem[pix_ff] <= bin_eff + 1'b1;
      end
      if (bin_re) begin
         bin_rd_ff <= bin_mem[bin_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_valid_ff  <= '0;
         bin_rd_vld_ff <= 1'b0;
      end else begin
         if (accept && cmd == he_pkg::CMD_CLEAR) begin
            bin_valid_ff <= '0;
         end else if (bin_we) begin
            bin_valid_ff[pix_ff] <= 1'b1;
         end
         if (bin_re) begin
            bin_rd_vld_ff <= bin_valid_ff[bin_raddr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cum_we) begin
         cum_mem[cum_waddr] <= cum_wdata;
      end
      if (cum_re) begin
         cum_rd_ff <= cum_mem[cum_raddr];
      end
   end

   // map arithmetic: num * 255 as (num << 8) - num
   assign span     = total_ff - lowest_ff;
   assign degen    = (span == '0) || (lowest_ff > total_ff);
   assign num      = cum_rd_ff - lowest_ff;
   assign dividend = (he_pkg::PROD_W'(num) << 8) - he_pkg::PROD_W'(num);
   assign div_load = (state_ff == S_SETUP) && !degen;

   he_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (dividend),
      .divisor  (span),
      .done     (div_done),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         total_ff  <= '0;
         lowest_ff <= '0;
         ready_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         strobe_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  pix_ff <= req_pixel_value;
                  case (cmd)
                     he_pkg::CMD_CLEAR: begin
                        total_ff <= '0;
                        ready_ff <= 1'b0;
                     end
                     he_pkg::CMD_COUNT: begin
                        state_ff <= S_COUNT;
                     end
                     he_pkg::CMD_MAP: begin
                        if (ready_ff) begin
                           state_ff <= S_SETUP;
                        end else begin
                           state_ff <= S_BUILD;
                           idx_ff   <= '0;
                           run_ff   <= '0;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_COUNT: begin
               if (room) begin
                  total_ff <= total_ff + 1'b1;
               end
               ready_ff <= 1'b0;
               state_ff <= S_IDLE;
            end
            S_BUILD: begin
               if (idx_ff != '0) begin
                  run_ff <= cum_wdata;
               end
               if (idx_ff == he_pkg::IDX_W'(1)) begin
                  lowest_ff <= cum_wdata;
               end
               if (idx_ff[he_pkg::BIN_AW]) begin
                  ready_ff <= 1'b1;
                  state_ff <= S_LOOKUP;
               end
               idx_ff <= idx_ff + 1'b1;
            end
            S_LOOKUP: begin
               state_ff <= S_SETUP;
            end
            S_SETUP: begin
               if (degen) begin
                  strobe_ff <= 1'b1;
                  eq_ff     <= '0;
                  deg_ff    <= 1'b1;
                  state_ff  <= S_IDLE;
               end else begin
                  state_ff <= S_DIVIDE;
               end
            end
            S_DIVIDE: begin
               if (div_done) begin
                  strobe_ff <= 1'b1;
                  eq_ff     <= quotient;
                  deg_ff    <= 1'b0;
                  state_ff  <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != S_IDLE);
   assign rsp_strobe          = strobe_ff;
   assign rsp_equalized_value = eq_ff;
   assign rsp_degenerate      = deg_ff;

endmodule

// ===== rtl/he_divider.sv =====
// he_divider: restoring divider, one quotient bit per cycle, 8-bit quotient.
// Expects dividend < divisor * 256. Depends on he_pkg.
module he_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  logic [he_pkg::PROD_W-1:0]    dividend,
   input  logic [he_pkg::COUNT_W-1:0]   divisor,
   output logic                         done,
   output logic [he_pkg::QUO_W-1:0]     quotient
);

   logic                          active_ff;
   logic                          done_ff;
   logic [he_pkg::STEP_W-1:0]     step_ff;
   logic [he_pkg::PROD_W-1:0]     rem_ff;
   logic [he_pkg::COUNT_W-1:0]    dvs_ff;
   logic [he_pkg::QUO_W-1:0]      quo_ff;
   logic [he_pkg::PROD_W-1:0]     shifted;
   logic                          fits;

   assign shifted = he_pkg::PROD_W'(dvs_ff) << step_ff;
   assign fits    = (rem_ff >= shifted);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         step_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            active_ff <= 1'b1;
            step_ff   <= he_pkg::STEP_W'(he_pkg::QUO_W - 1);
         end else if (active_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               active_ff <= 1'b0;
               done_ff   <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= dividend;
         dvs_ff <= divisor;
         quo_ff <= '0;
      end else if (active_ff && fits) begin
         rem_ff          <= rem_ff - shifted;
         quo_ff[step_ff] <= 1'b1;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/he_checker.sv =====
// he_checker: port-level assertions for histogram_equalizer, bound to the top.
// Depends on he_pkg.
module he_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [he_pkg::CMD_W-1:0]     req_command,
   input logic [he_pkg::PIX_W-1:0]     req_pixel_value,
   input logic                         rsp_strobe,
   input logic [he_pkg::QUO_W-1:0]     rsp_equalized_value,
   input logic                         rsp_degenerate
);

   // a response only ends a map transaction that held busy
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response without a preceding busy map transaction");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_degenerate) |-> (rsp_equalized_value == '0))
      else $error("degenerate response with nonzero value");

   // count holds busy for its read-modify-write of the bin memory
   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == he_pkg::CMD_COUNT) |=> busy)
      else $error("count transaction did not hold busy");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == he_pkg::CMD_CLEAR) |=> (!busy && !rsp_strobe))
      else $error("clear transaction caused busy or a response");

endmodule

bind histogram_equalizer he_checker u_checker (.*);
